// ----- hdl/wbm_pkg.sv -----
// Package of the windowed energy budget monitor: sizes, payload structs,
// configuration and level codes, controller command/status structs and lookup tables.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package wbm_pkg;

   // Ring depth and the widths that follow from it.
   localparam int WINDOW_MAX = 256;
   localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

   // Fixed field widths.
   localparam int ENERGY_W   = 32;
   localparam int SUM_W      = 40;
   localparam int PCT_W      = 16;
   localparam int PERIOD_W   = 16;
   localparam int WSAMP_W    = 9;
   localparam int GRACE_W    = 8;
   localparam int SCALED_W   = SUM_W + 7;
   localparam int PROD_W     = PCT_W + SUM_W;
   localparam int DIV_STEPS  = ENERGY_W;
   localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 40;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_REFILL = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_POLICY_MODE    = 3'd0,
      CSR_BUDGET         = 3'd1,
      CSR_PERIOD_LENGTH  = 3'd2,
      CSR_WINDOW_SAMPLES = 3'd3,
      CSR_LIMIT_LOW      = 3'd4,
      CSR_LIMIT_MID      = 3'd5,
      CSR_LIMIT_HIGH     = 3'd6,
      CSR_GRACE_COUNT    = 3'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      LVL_HELD   = 3'd0,
      LVL_SAFE   = 3'd1,
      LVL_WARN3  = 3'd2,
      LVL_WARN2  = 3'd3,
      LVL_PANIC  = 3'd4,
      LVL_REFILL = 3'd5
   } level_type;

   typedef enum logic [1:0] {
      LIM_LOW  = 2'd0,
      LIM_MID  = 2'd1,
      LIM_HIGH = 2'd2
   } lim_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_DIV,
      ST_FILL,
      ST_SUM,
      ST_SCALE,
      ST_MUL_LO,
      ST_CMP_LO,
      ST_MUL_MID,
      ST_CMP_MID,
      ST_MUL_HI,
      ST_CMP_HI,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                command;
      logic [ENERGY_W-1:0] energy;
   } req_type;

   typedef struct packed {
      level_type        level;
      logic [SUM_W-1:0] window_energy;
      logic [1:0]       pstate_step;
      logic [3:0]       threshold_step;
   } rsp_type;

   typedef struct packed {
      logic                policy_mode;
      logic [SUM_W-1:0]    budget;
      logic [PERIOD_W-1:0] period_length;
      logic [WSAMP_W-1:0]  window_samples;
      logic [PCT_W-1:0]    limit_low;
      logic [PCT_W-1:0]    limit_mid;
      logic [PCT_W-1:0]    limit_high;
      logic [GRACE_W-1:0]  grace_count;
   } cfg_type;

   typedef struct packed {
      logic        accept;
      logic        start;
      logic        fill_run;
      logic        sum_run;
      logic        scale;
      logic        mul_en;
      logic        cmp_en;
      lim_sel_type lim_sel;
      logic        finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_refill;
      logic div_done;
      logic fill_done;
      logic sum_done;
      logic hold_nz;
      logic out_busy;
   } ctrl_stat_type;

   function automatic logic [1:0] pstate_of(level_type lvl);
      logic [1:0] step;
      unique case (lvl)
         LVL_WARN2: step = 2'd2;
         LVL_PANIC: step = 2'd3;
         default:   step = 2'd0;
      endcase
      return step;
   endfunction

   function automatic logic [3:0] thresh_of(level_type lvl);
      logic [3:0] step;
      unique case (lvl)
         LVL_WARN3: step = 4'd5;
         LVL_WARN2: step = 4'd10;
         LVL_PANIC: step = 4'd10;
         default:   step = 4'd0;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wbm_csr.sv -----
// Configuration registers of the energy budget monitor, written through a plain write port.
// Depends on wbm_pkg for the register index codes and the cfg_type struct.
`default_nettype none

module wbm_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [wbm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [wbm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output wbm_pkg::cfg_type                    cfg
);

   wbm_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (wbm_pkg::csr_idx_type'(csr_addr))
            wbm_pkg::CSR_POLICY_MODE:    cfg_in.policy_mode    = csr_wdata[0];
            wbm_pkg::CSR_BUDGET:         cfg_in.budget         = csr_wdata[wbm_pkg::SUM_W-1:0];
            wbm_pkg::CSR_PERIOD_LENGTH:
               cfg_in.period_length  = csr_wdata[wbm_pkg::PERIOD_W-1:0];
            wbm_pkg::CSR_WINDOW_SAMPLES:
               cfg_in.window_samples = csr_wdata[wbm_pkg::WSAMP_W-1:0];
            wbm_pkg::CSR_LIMIT_LOW:      cfg_in.limit_low      = csr_wdata[wbm_pkg::PCT_W-1:0];
            wbm_pkg::CSR_LIMIT_MID:      cfg_in.limit_mid      = csr_wdata[wbm_pkg::PCT_W-1:0];
            wbm_pkg::CSR_LIMIT_HIGH:     cfg_in.limit_high     = csr_wdata[wbm_pkg::PCT_W-1:0];
            wbm_pkg::CSR_GRACE_COUNT:    cfg_in.grace_count    = csr_wdata[wbm_pkg::GRACE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy_mode    <= 1'b0;
         cfg_ff.budget         <= wbm_pkg::SUM_W'(1);
         cfg_ff.period_length  <= wbm_pkg::PERIOD_W'(1);
         cfg_ff.window_samples <= wbm_pkg::WSAMP_W'(1);
         cfg_ff.limit_low      <= wbm_pkg::PCT_W'(70);
         cfg_ff.limit_mid      <= wbm_pkg::PCT_W'(85);
         cfg_ff.limit_high     <= wbm_pkg::PCT_W'(95);
         cfg_ff.grace_count    <= wbm_pkg::GRACE_W'(3);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/wbm_ctrl.sv -----
// Sequencer of the energy budget monitor: walks one beat through divide, fill or
// sum, scaling, the three limit compares and result hand-off. Depends on wbm_pkg.
`default_nettype none

module wbm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wbm_pkg::ctrl_stat_type     stat,
   output wbm_pkg::ctrl_cmd_type      cmd
);

   wbm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wbm_pkg::ST_IDLE:    if (req_valid) state_in = wbm_pkg::ST_START;
         wbm_pkg::ST_START:   state_in = stat.is_refill ? wbm_pkg::ST_DIV : wbm_pkg::ST_SUM;
         wbm_pkg::ST_DIV:     if (stat.div_done) state_in = wbm_pkg::ST_FILL;
         wbm_pkg::ST_FILL:    if (stat.fill_done) state_in = wbm_pkg::ST_FINISH;
         wbm_pkg::ST_SUM:     if (stat.sum_done && stat.div_done) state_in = wbm_pkg::ST_SCALE;
         wbm_pkg::ST_SCALE:   state_in = stat.hold_nz ? wbm_pkg::ST_FINISH : wbm_pkg::ST_MUL_LO;
         wbm_pkg::ST_MUL_LO:  state_in = wbm_pkg::ST_CMP_LO;
         wbm_pkg::ST_CMP_LO:  state_in = wbm_pkg::ST_MUL_MID;
         wbm_pkg::ST_MUL_MID: state_in = wbm_pkg::ST_CMP_MID;
         wbm_pkg::ST_CMP_MID: state_in = wbm_pkg::ST_MUL_HI;
         wbm_pkg::ST_MUL_HI:  state_in = wbm_pkg::ST_CMP_HI;
         wbm_pkg::ST_CMP_HI:  state_in = wbm_pkg::ST_FINISH;
         wbm_pkg::ST_FINISH:  if (!stat.out_busy) state_in = wbm_pkg::ST_IDLE;
         default:             state_in = wbm_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.lim_sel = wbm_pkg::LIM_LOW;
      unique case (state_ff)
         wbm_pkg::ST_IDLE:    cmd.accept = req_valid;
         wbm_pkg::ST_START:   cmd.start = 1'b1;
         wbm_pkg::ST_FILL:    cmd.fill_run = !stat.fill_done;
         wbm_pkg::ST_SUM:     cmd.sum_run = 1'b1;
         wbm_pkg::ST_SCALE:   cmd.scale = 1'b1;
         wbm_pkg::ST_MUL_LO:  cmd.mul_en = 1'b1;
         wbm_pkg::ST_CMP_LO:  cmd.cmp_en = 1'b1;
         wbm_pkg::ST_MUL_MID: begin
            cmd.mul_en  = 1'b1;
            cmd.lim_sel = wbm_pkg::LIM_MID;
         end
         wbm_pkg::ST_CMP_MID: begin
            cmd.cmp_en  = 1'b1;
            cmd.lim_sel = wbm_pkg::LIM_MID;
         end
         wbm_pkg::ST_MUL_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.lim_sel = wbm_pkg::LIM_HIGH;
         end
         wbm_pkg::ST_CMP_HI: begin
            cmd.cmp_en  = 1'b1;
            cmd.lim_sel = wbm_pkg::LIM_HIGH;
         end
         wbm_pkg::ST_FINISH:  cmd.finish = !stat.out_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wbm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != wbm_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ----- hdl/wbm_dpath.sv -----
// Datapath of the energy budget monitor: sample ring memory, window sum sweep,
// shared restoring divider, limit multiply/compare, hold counter and result register.
// Depends on wbm_pkg; driven by wbm_ctrl through ctrl_cmd_type.
`default_nettype none

module wbm_dpath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wbm_pkg::cfg_type       cfg,
   input  wbm_pkg::req_type       req_data,
   input  wbm_pkg::ctrl_cmd_type  cmd,
   output wbm_pkg::ctrl_stat_type stat,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wbm_pkg::rsp_type       rsp_data
);

   localparam int SLOT_W   = wbm_pkg::SLOT_W;
   localparam int CNT_W    = wbm_pkg::CNT_W;
   localparam int ENERGY_W = wbm_pkg::ENERGY_W;
   localparam int SUM_W    = wbm_pkg::SUM_W;
   localparam int DIV_W    = wbm_pkg::PERIOD_W;

   logic [ENERGY_W-1:0] ring_mem [wbm_pkg::WINDOW_MAX];

   wbm_pkg::req_type             req_ff, req_in;
   logic [SLOT_W-1:0]            write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]             filled_ff, filled_in;
   logic [wbm_pkg::GRACE_W-1:0]  hold_ff, hold_in;
   logic [CNT_W-1:0]             idx_ff, idx_in;
   logic [SUM_W-1:0]             acc_ff, acc_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [ENERGY_W-1:0]          rd_data_ff;
   logic                         div_busy_ff, div_busy_in;
   logic [wbm_pkg::DCNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [ENERGY_W-1:0]          div_quot_ff, div_quot_in;
   logic [DIV_W-1:0]             div_rem_ff, div_rem_in;
   logic [DIV_W-1:0]             div_den_ff, div_den_in;
   logic [wbm_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic [wbm_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [2:0]                   below_ff, below_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   wbm_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [CNT_W-1:0]          w_eff;
   logic [CNT_W-1:0]          sum_lim;
   logic [SLOT_W-1:0]         slot_sel;
   logic [SLOT_W-1:0]         slot_next;
   logic [DIV_W:0]            rem_shift;
   logic                      rem_ge;
   logic [wbm_pkg::PCT_W-1:0] lim_val;
   logic                      issue;
   logic                      mem_we;
   logic [SLOT_W-1:0]         mem_waddr;
   logic [ENERGY_W-1:0]       mem_wdata;
   wbm_pkg::level_type        lvl;

   // Window size clamped into 1..WINDOW_MAX.
   always_comb begin
      if (cfg.window_samples == '0) begin
         w_eff = CNT_W'(1);
      end else if (int'(cfg.window_samples) > wbm_pkg::WINDOW_MAX) begin
         w_eff = CNT_W'(wbm_pkg::WINDOW_MAX);
      end else begin
         w_eff = CNT_W'(cfg.window_samples);
      end
   end

   assign sum_lim   = (filled_ff < w_eff) ? filled_ff : w_eff;
   assign slot_sel  = (CNT_W'(write_slot_ff) < w_eff) ? write_slot_ff : '0;
   assign slot_next = ((CNT_W'(slot_sel) + CNT_W'(1)) == w_eff) ? '0 : slot_sel + SLOT_W'(1);
   assign rem_shift = {div_rem_ff, div_quot_ff[ENERGY_W-1]};
   assign rem_ge    = (rem_shift >= {1'b0, div_den_ff});
   assign issue     = (idx_ff < sum_lim);

   always_comb begin
      unique case (cmd.lim_sel)
         wbm_pkg::LIM_LOW:  lim_val = cfg.limit_low;
         wbm_pkg::LIM_MID:  lim_val = cfg.limit_mid;
         wbm_pkg::LIM_HIGH: lim_val = cfg.limit_high;
         default:           lim_val = cfg.limit_high;
      endcase
   end

   // Level of a sample beat that is not held; a zero budget never passes a compare.
   always_comb begin
      priority if (below_ff[wbm_pkg::LIM_LOW]) begin
         lvl = wbm_pkg::LVL_SAFE;
      end else if (below_ff[wbm_pkg::LIM_MID]) begin
         lvl = wbm_pkg::LVL_WARN3;
      end else if (below_ff[wbm_pkg::LIM_HIGH]) begin
         lvl = wbm_pkg::LVL_WARN2;
      end else begin
         lvl = wbm_pkg::LVL_PANIC;
      end
   end

   always_comb begin
      req_in        = req_ff;
      write_slot_in = write_slot_ff;
      filled_in     = filled_ff;
      hold_in       = hold_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      rd_pend_in    = 1'b0;
      div_busy_in   = div_busy_ff;
      div_cnt_in    = div_cnt_ff;
      div_quot_in   = div_quot_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      scaled_in     = scaled_ff;
      prod_in       = prod_ff;
      below_in      = below_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      mem_we        = 1'b0;
      mem_waddr     = slot_sel;
      mem_wdata     = req_ff.energy;

      if (cmd.accept) begin
         req_in = req_data;
      end

      // Restoring divider, one quotient bit per cycle.
      if (cmd.start) begin
         div_busy_in = 1'b1;
         div_cnt_in  = '0;
         div_quot_in = req_ff.energy;
         div_rem_in  = '0;
         if (req_ff.command == wbm_pkg::CMD_REFILL) begin
            div_den_in = DIV_W'(w_eff);
         end else begin
            div_den_in = (cfg.period_length == '0) ? DIV_W'(1) : cfg.period_length;
         end
      end else if (div_busy_ff) begin
         div_quot_in = {div_quot_ff[ENERGY_W-2:0], rem_ge};
         div_rem_in  = rem_ge ? DIV_W'(rem_shift - {1'b0, div_den_ff}) : rem_shift[DIV_W-1:0];
         div_cnt_in  = div_cnt_ff + wbm_pkg::DCNT_W'(1);
         div_busy_in = (div_cnt_ff != wbm_pkg::DCNT_W'(wbm_pkg::DIV_STEPS - 1));
      end

      if (cmd.start) begin
         idx_in = '0;
         acc_in = '0;
         if (req_ff.command == wbm_pkg::CMD_REFILL) begin
            filled_in     = w_eff;
            write_slot_in = '0;
         end else begin
            mem_we        = 1'b1;
            write_slot_in = slot_next;
            if (filled_ff < w_eff) begin
               filled_in = filled_ff + CNT_W'(1);
            end
         end
      end else if (cmd.fill_run) begin
         mem_we    = 1'b1;
         mem_waddr = idx_ff[SLOT_W-1:0];
         mem_wdata = div_quot_ff;
         acc_in    = acc_ff + SUM_W'(div_quot_ff);
         idx_in    = idx_ff + CNT_W'(1);
      end else if (cmd.sum_run) begin
         // At most WINDOW_MAX words of 32 bits: the sum cannot reach 2^40.
         rd_pend_in = issue;
         if (issue) begin
            idx_in = idx_ff + CNT_W'(1);
         end
         if (rd_pend_ff) begin
            acc_in = acc_ff + SUM_W'(rd_data_ff);
         end
      end

      if (cmd.scale) begin
         if (cfg.policy_mode) begin
            scaled_in = wbm_pkg::SCALED_W'(div_quot_ff) * wbm_pkg::SCALED_W'(100);
         end else begin
            scaled_in = wbm_pkg::SCALED_W'(acc_ff) * wbm_pkg::SCALED_W'(100);
         end
      end

      if (cmd.mul_en) begin
         prod_in = wbm_pkg::PROD_W'(lim_val) * wbm_pkg::PROD_W'(cfg.budget);
      end

      if (cmd.cmp_en) begin
         below_in[cmd.lim_sel] = (wbm_pkg::PROD_W'(scaled_ff) < prod_ff);
      end

      if (cmd.finish) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.window_energy   = acc_ff;
         rsp_data_in.pstate_step     = 2'd0;
         rsp_data_in.threshold_step  = 4'd0;
         if (req_ff.command == wbm_pkg::CMD_REFILL) begin
            rsp_data_in.level = wbm_pkg::LVL_REFILL;
         end else if (hold_ff != '0) begin
            rsp_data_in.level = wbm_pkg::LVL_HELD;
            hold_in           = hold_ff - wbm_pkg::GRACE_W'(1);
         end else begin
            rsp_data_in.level          = lvl;
            rsp_data_in.pstate_step    = wbm_pkg::pstate_of(lvl);
            rsp_data_in.threshold_step = wbm_pkg::thresh_of(lvl);
            // The counter is zero here, so adding the grace count cannot saturate.
            if (lvl != wbm_pkg::LVL_SAFE) begin
               hold_in = cfg.grace_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.sum_run && issue) begin
         rd_data_ff <= ring_mem[idx_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         filled_ff     <= '0;
         hold_ff       <= '0;
         idx_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         div_busy_ff   <= 1'b0;
         div_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         write_slot_ff <= write_slot_in;
         filled_ff     <= filled_in;
         hold_ff       <= hold_in;
         idx_ff        <= idx_in;
         rd_pend_ff    <= rd_pend_in;
         div_busy_ff   <= div_busy_in;
         div_cnt_ff    <= div_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      acc_ff      <= acc_in;
      div_quot_ff <= div_quot_in;
      div_rem_ff  <= div_rem_in;
      div_den_ff  <= div_den_in;
      scaled_ff   <= scaled_in;
      prod_ff     <= prod_in;
      below_ff    <= below_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.is_refill = (req_ff.command == wbm_pkg::CMD_REFILL);
   assign stat.div_done  = !div_busy_ff;
   assign stat.fill_done = (idx_ff == w_eff);
   assign stat.sum_done  = (idx_ff == sum_lim) && !rd_pend_ff;
   assign stat.hold_nz   = (hold_ff != '0);
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_finish_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while a beat is still waiting");

   a_slot_inside_window: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && req_ff.command == wbm_pkg::CMD_SAMPLE) |=> (CNT_W'(write_slot_ff) < w_eff))
      else $error("write slot left the window after a sample");

   // A window shrunk without a refill leaves the fill count above it, so only the
   // ring depth bounds the count.
   a_filled_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (filled_ff <= CNT_W'(wbm_pkg::WINDOW_MAX)))
      else $error("fill count exceeds the ring depth after an update");

   a_div_steps_bounded: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (div_cnt_ff < wbm_pkg::DCNT_W'(wbm_pkg::DIV_STEPS)))
      else $error("divider ran past its last quotient bit");

   a_sweep_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.sum_run |-> (idx_ff <= sum_lim))
      else $error("window sweep read past the filled slots");

endmodule

`default_nettype wire

// ----- hdl/windowed_energy_budget_monitor_top.sv -----
// Windowed energy budget monitor, top level.
// Channels: req_valid/req_stall/req_data carry one beat per period, either a sample
// or a refill total; rsp_valid/rsp_stall/rsp_data return exactly one result per beat.
// csr_we/csr_addr/csr_wdata write the eight configuration registers; the user must
// write them only while idle; the block does not enforce it. One beat is worked on
// at a time; req_stall is high from acceptance until the result has been loaded into
// the output register. A sample beat sweeps L = min(fill count, window) ring slots
// through the single memory read port, at most 256, while the 32-step shared divider
// runs alongside; scaling and the three limit multiply/compare pairs follow.
// A held sample skips the three limit multiply/compare pairs.
// A refill beat runs 32 divider steps, then one ring write per slot of the W-slot
// window.
// The result register lets the next beat be accepted while the previous result is
// still stalled; only the hand-off of a new result waits for rsp_stall to drop.
// Reset restores the register defaults and clears slot pointer, fill count, hold
// counter and result valid; the ring contents are not cleared.
// Depends on wbm_pkg, wbm_csr, wbm_ctrl and wbm_dpath.
`default_nettype none

module windowed_energy_budget_monitor_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wbm_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output wbm_pkg::rsp_type                    rsp_data,
   input  wire logic                           csr_we,
   input  wire logic [wbm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [wbm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wbm_pkg::cfg_type       cfg;
   wbm_pkg::ctrl_cmd_type  cmd;
   wbm_pkg::ctrl_stat_type stat;

   wbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wbm_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- dv/windowed_energy_budget_monitor_checker.sv -----
// Checker for the windowed energy budget monitor: follows register writes, predicts the
// result of every accepted request beat and compares it with each accepted response beat.
// Depends on wbm_pkg for the payload structs, register indexes and level codes.
module windowed_energy_budget_monitor_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  wbm_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  wbm_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [wbm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [wbm_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import wbm_pkg::*;

   localparam logic [SUM_W-1:0] SUM_MAX     = '1;
   localparam logic [1:0]       PSTEP_WARN2 = 2'd2;
   localparam logic [1:0]       PSTEP_PANIC = 2'd3;
   localparam logic [3:0]       TSTEP_WARN3 = 4'd5;
   localparam logic [3:0]       TSTEP_HIGH  = 4'd10;

   logic                cfg_mode;
   logic [SUM_W-1:0]    cfg_budget;
   logic [PERIOD_W-1:0] cfg_period;
   logic [WSAMP_W-1:0]  cfg_window;
   logic [PCT_W-1:0]    cfg_low, cfg_mid, cfg_high;
   logic [GRACE_W-1:0]  cfg_grace;

   logic [ENERGY_W-1:0] ring [WINDOW_MAX];
   logic [SLOT_W-1:0]   next_slot;
   logic [CNT_W-1:0]    fill_count;
   logic [SUM_W-1:0]    window_total;
   logic [GRACE_W-1:0]  hold_left;

   rsp_type expected_results[$];
   int      reported = 0;
   int      rsp_beats = 0;

   function automatic int unsigned active_slots();
      int unsigned w;
      w = cfg_window;
      if (w == 0) w = 1;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      return w;
   endfunction

   // Sum over the slots that count toward the window, saturating at the field width.
   function automatic logic [SUM_W-1:0] sum_filled();
      int unsigned       lim;
      longint unsigned   s;
      lim = (fill_count < active_slots()) ? fill_count : active_slots();
      s = 0;
      for (int i = 0; i < lim; i++) begin
         s += ring[i];
         if (s > SUM_MAX) s = SUM_MAX;
      end
      return s[SUM_W-1:0];
   endfunction

   task automatic predict_budget_result(input req_type beat, output rsp_type res);
      int unsigned     w, slot, h;
      longint unsigned scaled, divisor;
      level_type       lvl;
      logic [1:0]      ps;
      logic [3:0]      ts;
      w = active_slots();
      ps = '0;
      ts = '0;
      lvl = LVL_HELD;
      if (beat.command == CMD_REFILL) begin
         for (int i = 0; i < w; i++) ring[i] = beat.energy / w;
         fill_count = CNT_W'(w);
         next_slot = '0;
         window_total = sum_filled();
         lvl = LVL_REFILL;
      end else begin
         // A write pointer left outside a shrunken window restarts at slot zero.
         slot = (next_slot < w) ? next_slot : 0;
         ring[slot] = beat.energy;
         next_slot = SLOT_W'((slot + 1) % w);
         if (fill_count < w) fill_count++;
         window_total = sum_filled();
         if (hold_left != 0) begin
            hold_left--;
         end else begin
            if (cfg_mode == 1'b0) begin
               scaled = 64'(window_total) * 64'd100;
            end else begin
               divisor = (cfg_period == 0) ? 64'd1 : 64'(cfg_period);
               scaled = (64'(beat.energy) / divisor) * 64'd100;
            end
            if (scaled < 64'(cfg_low) * 64'(cfg_budget)) begin
               lvl = LVL_SAFE;
            end else if (scaled < 64'(cfg_mid) * 64'(cfg_budget)) begin
               lvl = LVL_WARN3;
               ts = TSTEP_WARN3;
            end else if (scaled < 64'(cfg_high) * 64'(cfg_budget)) begin
               lvl = LVL_WARN2;
               ps = PSTEP_WARN2;
               ts = TSTEP_HIGH;
            end else begin
               lvl = LVL_PANIC;
               ps = PSTEP_PANIC;
               ts = TSTEP_HIGH;
            end
            if (lvl != LVL_SAFE) begin
               h = hold_left + cfg_grace;
               hold_left = (h > 255) ? 8'd255 : GRACE_W'(h);
            end
         end
      end
      res.level = lvl;
      res.window_energy = window_total;
      res.pstate_step = ps;
      res.threshold_step = ts;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cfg_mode = 1'b0;
         cfg_budget = 1;
         cfg_period = 1;
         cfg_window = 1;
         cfg_low = 70;
         cfg_mid = 85;
         cfg_high = 95;
         cfg_grace = 3;
         foreach (ring[i]) ring[i] = '0;
         next_slot = '0;
         fill_count = '0;
         window_total = '0;
         hold_left = '0;
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_POLICY_MODE:    cfg_mode = csr_wdata[0];
               CSR_BUDGET:         cfg_budget = csr_wdata[SUM_W-1:0];
               CSR_PERIOD_LENGTH:  cfg_period = csr_wdata[PERIOD_W-1:0];
               CSR_WINDOW_SAMPLES: cfg_window = csr_wdata[WSAMP_W-1:0];
               CSR_LIMIT_LOW:      cfg_low = csr_wdata[PCT_W-1:0];
               CSR_LIMIT_MID:      cfg_mid = csr_wdata[PCT_W-1:0];
               CSR_LIMIT_HIGH:     cfg_high = csr_wdata[PCT_W-1:0];
               CSR_GRACE_COUNT:    cfg_grace = csr_wdata[GRACE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_budget_result(req_data, want);
            expected_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (reported < 10)
                  $display("response beat %0d arrived with no result expected: level %0d energy %0d",
                           rsp_beats, rsp_data.level, rsp_data.window_energy);
               reported++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.level !== want.level ||
                   rsp_data.window_energy !== want.window_energy ||
                   rsp_data.pstate_step !== want.pstate_step ||
                   rsp_data.threshold_step !== want.threshold_step) begin
                  fail_count++;
                  if (reported < 10)
                     $display({"response beat %0d mismatch: expected level %0d energy %0d ",
                               "pstate %0d threshold %0d, got level %0d energy %0d ",
                               "pstate %0d threshold %0d"},
                              rsp_beats, want.level, want.window_energy, want.pstate_step,
                              want.threshold_step, rsp_data.level, rsp_data.window_energy,
                              rsp_data.pstate_step, rsp_data.threshold_step);
                  reported++;
               end
            end
            rsp_beats++;
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// ----- dv/windowed_energy_budget_monitor_top_tb.sv -----
// Top of the windowed energy budget monitor testbench: clock, reset, register setup,
// request stimulus, response back-pressure and the verdict.
// Depends on wbm_pkg, the block's top level and windowed_energy_budget_monitor_checker.
module windowed_energy_budget_monitor_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wbm_pkg::*;

   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int PHASES        = 12;
   localparam int PHASE_BEATS   = 154;
   localparam int HOLD_OFF_LONG = 1500;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_off_request = 1'b0;
   int hold_off_left = 0;

   // Settings as last written, used to aim the energy figures and to track written slots.
   logic             mode_now = 1'b0;
   logic [SUM_W-1:0] budget_now = 1;
   logic [15:0]      period_now = 1;
   int unsigned      window_now = 1;
   int unsigned      slots_written = 0;

   always #4 clock = ~clock;

   windowed_energy_budget_monitor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   windowed_energy_budget_monitor_checker monitor_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("windowed_energy_budget_monitor_top_tb: FAIL");
         $finish;
      end
   end

   // Response back-pressure, with one long hold-off that fills the block.
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left = HOLD_OFF_LONG;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic configure(input logic mode, input logic [SUM_W-1:0] bud,
                            input logic [15:0] per, input logic [8:0] win,
                            input logic [15:0] lo, input logic [15:0] mi,
                            input logic [15:0] hi, input logic [7:0] gr);
      write_reg(CSR_POLICY_MODE, CSR_DATA_W'(mode));
      write_reg(CSR_BUDGET, CSR_DATA_W'(bud));
      write_reg(CSR_PERIOD_LENGTH, CSR_DATA_W'(per));
      write_reg(CSR_WINDOW_SAMPLES, CSR_DATA_W'(win));
      write_reg(CSR_LIMIT_LOW, CSR_DATA_W'(lo));
      write_reg(CSR_LIMIT_MID, CSR_DATA_W'(mi));
      write_reg(CSR_LIMIT_HIGH, CSR_DATA_W'(hi));
      write_reg(CSR_GRACE_COUNT, CSR_DATA_W'(gr));
      csr_we <= 1'b0;
      mode_now = mode;
      budget_now = bud;
      period_now = per;
      window_now = (win == 0) ? 1 : ((win > WINDOW_MAX) ? WINDOW_MAX : win);
   endtask

   // Entered and left at a falling edge; valid stays up across back-to-back beats.
   task automatic send_beat(input logic cmd, input logic [ENERGY_W-1:0] energy);
      req_type beat;
      beat.command = cmd;
      beat.energy = energy;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (cmd == CMD_REFILL && window_now > slots_written) slots_written = window_now;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // Mostly figures aimed near the limits for the current budget, window and period.
   function automatic logic [ENERGY_W-1:0] pick_energy(input logic refill);
      int unsigned     roll, pct;
      longint unsigned target;
      roll = $urandom_range(99);
      if (roll < 8) return $urandom;
      if (roll < 11) return '0;
      if (roll < 14) return '1;
      pct = $urandom_range(130);
      if (refill || mode_now == 1'b0) begin
         target = 64'(budget_now) * pct / 100;
         if (!refill) target = target / window_now;
      end else begin
         target = 64'(budget_now) * pct * ((period_now == 0) ? 1 : period_now) / 100;
      end
      target += $urandom_range(3);
      return (target > 64'hFFFF_FFFF) ? '1 : ENERGY_W'(target);
   endfunction

   task automatic run_directed();
      idle_pct = 0;
      stall_pct = 0;
      // Reset settings: a one-slot window, unit budget, limits 70/85/95, grace of three.
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_SAMPLE, 32'd1);
      send_beat(CMD_SAMPLE, 32'd5);
      send_beat(CMD_SAMPLE, 32'd7);
      send_beat(CMD_SAMPLE, 32'd9);
      send_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
      send_beat(CMD_REFILL, 32'hFFFF_FFFF);
      slots_written = 1;
      // Zero budget panics on everything; a zero window acts as one slot.
      drain_results();
      configure(1'b0, 40'd0, 16'd1, 9'd0, 16'd70, 16'd85, 16'd95, 8'd0);
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_SAMPLE, 32'd12345);
      // Power mode with a zero period, and an oversized window clamped to the ring.
      drain_results();
      configure(1'b1, 40'd100, 16'd0, 9'h1FF, 16'd70, 16'd85, 16'd95, 8'd0);
      send_beat(CMD_REFILL, 32'hFFFF_FFFF);
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_SAMPLE, 32'd69);
      send_beat(CMD_SAMPLE, 32'd70);
      send_beat(CMD_SAMPLE, 32'd84);
      send_beat(CMD_SAMPLE, 32'd85);
      send_beat(CMD_SAMPLE, 32'd94);
      send_beat(CMD_SAMPLE, 32'd95);
      send_beat(CMD_SAMPLE, 32'd65535);
      // Shrink to three slots without a refill; the write pointer sits outside it.
      drain_results();
      configure(1'b0, 40'hFF_FFFF_FFFF, 16'hFFFF, 9'd3, 16'd0, 16'd0, 16'hFFFF, 8'd255);
      send_beat(CMD_SAMPLE, 32'hFFFF_FFFF);
      send_beat(CMD_SAMPLE, 32'd0);
      send_beat(CMD_SAMPLE, 32'd1);
      send_beat(CMD_REFILL, 32'd0);
      send_beat(CMD_SAMPLE, 32'd7);
   endtask

   task automatic run_random_phase(input int index, input int count);
      logic        mode;
      logic [39:0] bud;
      logic [15:0] per, lo, mi, hi;
      logic [8:0]  win;
      logic [7:0]  gr;
      logic        cmd;
      int unsigned roll;
      mode = 1'($urandom_range(1));
      roll = $urandom_range(9);
      if (roll < 3) bud = 40'($urandom_range(1, 2000));
      else if (roll < 7) bud = {8'd0, $urandom};
      else if (roll < 9) bud = {8'($urandom), $urandom};
      else bud = 40'hFF_FFFF_FFFF;
      roll = $urandom_range(9);
      if (roll < 6) per = 16'($urandom_range(1, 64));
      else if (roll < 9) per = 16'($urandom_range(1, 65535));
      else per = 16'hFFFF;
      if (index % 5 == 3) win = 9'd256;
      else if (index == PHASES - 1) win = 9'($urandom_range(1, 256));
      else win = 9'($urandom_range(1, 12));
      if ($urandom_range(9) < 8) begin
         lo = 16'($urandom_range(20, 80));
         mi = 16'(lo + $urandom_range(20));
         hi = 16'(mi + $urandom_range(20));
      end else begin
         lo = 16'($urandom_range(65535));
         mi = 16'($urandom_range(65535));
         hi = 16'($urandom_range(65535));
      end
      roll = $urandom_range(19);
      if (roll < 4) gr = 8'd0;
      else if (roll < 19) gr = 8'($urandom_range(1, 6));
      else gr = 8'($urandom_range(255));
      configure(mode, bud, per, win, lo, mi, hi, gr);
      case (index % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 49; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 49; end
         default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      // A window larger than anything written so far must be refilled before use.
      if (window_now > slots_written) send_beat(CMD_REFILL, pick_energy(1'b1));
      for (int i = 0; i < count; i++) begin
         if (index == 2 && i == 30) hold_off_request = 1'b1;
         if (index == 5 && i == 60) drain_results();
         cmd = ($urandom_range(99) < 8) ? CMD_REFILL : CMD_SAMPLE;
         send_beat(cmd, pick_energy(cmd));
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         run_random_phase(p, PHASE_BEATS);
      end
      drain_results();
      repeat (300) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("windowed_energy_budget_monitor_top_tb: PASS");
      end else begin
         $display("windowed_energy_budget_monitor_top_tb: FAIL");
      end
      $finish;
   end

endmodule
